[sv/pkbu_pkg.sv]
// Shared constants, types and helpers for the palette key bit unpacker.
`timescale 1ns / 1ps

package pkbu_pkg;

  // Chunk and palette geometry (row width and tile count are powers of two)
  localparam int TilesPerChunk = 1024;
  localparam int PaletteDepth  = 1024;
  localparam int RowWidth      = 32;

  localparam int TileW   = $clog2(TilesPerChunk);
  localparam int RowBits = $clog2(RowWidth);
  localparam int KeyW    = $clog2(PaletteDepth);
  localparam int KCntW   = $clog2(KeyW + 1);
  localparam int SizeW   = 11;
  localparam int BaseW   = 16;
  localparam int CoordW  = 21;
  localparam int IdW     = 64;
  localparam int ByteW   = 8;
  localparam int RemW    = $clog2(ByteW + 1);
  localparam int CfgIdxW = 2;

  // Beat operation codes
  localparam logic OpPalette = 1'b0;
  localparam logic OpByte    = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPaletteSize = 2'd0;
  localparam logic [CfgIdxW-1:0] RegChunkBaseX  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegChunkBaseY  = 2'd2;

  // Completed key handed from the unpacker to the palette lookup
  typedef struct packed {
    logic             valid;
    logic [KeyW-1:0]  key;
    logic [TileW-1:0] tile;
  } issue_t;

  // Key width: smallest k >= 1 with 2**k >= size, capped at KeyW
  function automatic logic [KCntW-1:0] key_width(input logic [SizeW-1:0] size);
    logic [KCntW-1:0] k;
    k = KCntW'(1);
    for (int j = 1; j < KeyW; j++) begin
      if (size > (SizeW'(1) << j)) k = KCntW'(j + 1);
    end
    return k;
  endfunction

endpackage

[sv/pkbu_if.sv]
// Valid/ready channel interfaces for input beats and tile results.
`timescale 1ns / 1ps

interface pkbu_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [pkbu_pkg::KeyW-1:0]     palette_index;
  logic [pkbu_pkg::IdW-1:0]      palette_value;
  logic [pkbu_pkg::ByteW-1:0]    packed_byte;

  modport source (output valid, operation, palette_index, palette_value, packed_byte,
                  input ready);
  modport sink (input valid, operation, palette_index, palette_value, packed_byte,
                output ready);
endinterface

interface pkbu_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pkbu_pkg::CoordW-1:0] tile_x;
  logic signed [pkbu_pkg::CoordW-1:0] tile_y;
  logic [pkbu_pkg::IdW-1:0]          tile_id;
  logic                              bad_key;
  logic                              last_tile;

  modport source (output valid, tile_x, tile_y, tile_id, bad_key, last_tile,
                  input ready);
  modport sink (input valid, tile_x, tile_y, tile_id, bad_key, last_tile,
                output ready);
endinterface

[sv/palette_key_bit_unpacker_unit.sv]
// Palette key bit unpacker: one key slice per cycle, one palette read per tile.
// Throughput: one key or key fragment per cycle, held while a completed key waits for
//   the lookup stage; a byte or palette write beat is accepted as the last slice of
//   the current byte is taken or when no byte is left. Path: a completed key goes
//   through the palette read, then the output register.
// Reset: palette size 1, bases 0, tile count at the first tile; palette RAM not reset.
`timescale 1ns / 1ps

module palette_key_bit_unpacker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pkbu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pkbu_pkg::BaseW-1:0]    cfg_wdata_i,
  pkbu_in_if.sink                       in_i,
  pkbu_out_if.source                    out_o
);

  // Configuration registers
  logic [pkbu_pkg::SizeW-1:0] psize_q;
  logic [pkbu_pkg::KCntW-1:0] kw_q;
  logic [pkbu_pkg::BaseW-1:0] basex_q, basey_q;
  logic                       clr_partial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psize_q <= pkbu_pkg::SizeW'(1);
      kw_q    <= pkbu_pkg::KCntW'(1);
      basex_q <= '0;
      basey_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pkbu_pkg::RegPaletteSize: begin
          psize_q <= cfg_wdata_i[pkbu_pkg::SizeW-1:0];
          kw_q    <= pkbu_pkg::key_width(cfg_wdata_i[pkbu_pkg::SizeW-1:0]);
        end
        pkbu_pkg::RegChunkBaseX: basex_q <= cfg_wdata_i;
        pkbu_pkg::RegChunkBaseY: basey_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign clr_partial = cfg_we_i && (cfg_idx_i == pkbu_pkg::RegPaletteSize);

  // Input beat decode
  logic in_acc, pal_wr, byte_ld, unp_ready;
  assign in_acc  = in_i.valid && in_i.ready;
  assign pal_wr  = in_acc && (in_i.operation == pkbu_pkg::OpPalette);
  assign byte_ld = in_acc && (in_i.operation == pkbu_pkg::OpByte);
  assign in_i.ready = unp_ready;

  // Pipeline handshakes: lookup stage and output register
  logic r_valid_q, o_valid_q, o_free, r_adv, issue_rdy;
  assign o_free    = !o_valid_q || out_o.ready;
  assign r_adv     = r_valid_q && o_free;
  assign issue_rdy = !r_valid_q || o_free;

  pkbu_pkg::issue_t issue;

  pkbu_unpack u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (kw_q),
    .load_i      (byte_ld),
    .byte_i      (in_i.packed_byte),
    .rearm_i     (pal_wr),
    .clr_i       (clr_partial),
    .issue_rdy_i (issue_rdy),
    .ready_o     (unp_ready),
    .issue_o     (issue)
  );

  // Palette RAM: read-before-write, read data held until the next lookup
  logic [pkbu_pkg::IdW-1:0] pal_mem_q [pkbu_pkg::PaletteDepth];
  logic [pkbu_pkg::IdW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (pal_wr) pal_mem_q[in_i.palette_index] <= in_i.palette_value;
    if (issue.valid) rdata_q <= pal_mem_q[issue.key];
  end

  // Lookup stage side data
  logic signed [pkbu_pkg::CoordW-1:0] r_x_q, r_y_q;
  logic                               r_bad_q, r_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (issue.valid) begin
      r_valid_q <= 1'b1;
    end else if (o_free) begin
      r_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue.valid) begin
      r_x_q    <= {basex_q, issue.tile[pkbu_pkg::RowBits-1:0]};
      r_y_q    <= {basey_q, issue.tile[pkbu_pkg::TileW-1:pkbu_pkg::RowBits]};
      r_bad_q  <= (pkbu_pkg::SizeW'(issue.key) >= psize_q);
      r_last_q <= (issue.tile == '0);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (r_adv) begin
      o_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      o_valid_q <= 1'b0;
    end
  end

  logic signed [pkbu_pkg::CoordW-1:0] o_x_q, o_y_q;
  logic [pkbu_pkg::IdW-1:0]           o_id_q;
  logic                               o_bad_q, o_last_q;

  always_ff @(posedge clk_i) begin
    if (r_adv) begin
      o_x_q    <= r_x_q;
      o_y_q    <= r_y_q;
      o_id_q   <= r_bad_q ? '0 : rdata_q;
      o_bad_q  <= r_bad_q;
      o_last_q <= r_last_q;
    end
  end

  assign out_o.valid     = o_valid_q;
  assign out_o.tile_x    = o_x_q;
  assign out_o.tile_y    = o_y_q;
  assign out_o.tile_id   = o_id_q;
  assign out_o.bad_key   = o_bad_q;
  assign out_o.last_tile = o_last_q;

endmodule

[sv/pkbu_unpack.sv]
// Bit unpacker: slices packed bytes into keys and counts tiles down.
`timescale 1ns / 1ps

module pkbu_unpack (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pkbu_pkg::KCntW-1:0]    width_i,
  input  logic                          load_i,
  input  logic [pkbu_pkg::ByteW-1:0]    byte_i,
  input  logic                          rearm_i,
  input  logic                          clr_i,
  input  logic                          issue_rdy_i,
  output logic                          ready_o,
  output pkbu_pkg::issue_t              issue_o
);

  logic [pkbu_pkg::ByteW-1:0] byte_q, byte_d;
  logic [pkbu_pkg::RemW-1:0]  rem_q, rem_d;
  logic [pkbu_pkg::KeyW-1:0]  pkey_q, pkey_d;
  logic [pkbu_pkg::KCntW-1:0] pbits_q, pbits_d;
  logic [pkbu_pkg::TileW-1:0] tile_q, tile_d;
  logic                       done_q, done_d;

  logic [pkbu_pkg::KCntW-1:0]            need;
  logic [pkbu_pkg::RemW-1:0]             take;
  logic [pkbu_pkg::ByteW-1:0]            mask;
  logic [pkbu_pkg::KeyW+pkbu_pkg::ByteW-1:0] shifted;
  logic [pkbu_pkg::KeyW-1:0]             pkey_new;
  logic                                  busy, key_done, step, fin;

  // One slice per cycle unless a key waits: rest of key or of byte
  always_comb begin
    busy     = (rem_q != '0);
    need     = width_i - pbits_q;
    take     = (pkbu_pkg::RemW'(need) < rem_q) ? pkbu_pkg::RemW'(need) : rem_q;
    mask     = pkbu_pkg::ByteW'((9'(1) << take) - 9'(1));
    shifted  = (pkbu_pkg::KeyW + pkbu_pkg::ByteW)'(byte_q & mask) << pbits_q;
    pkey_new = pkey_q | shifted[pkbu_pkg::KeyW-1:0];
    key_done = (pkbu_pkg::KCntW'(take) == need);
    step     = busy && (!key_done || issue_rdy_i);
    fin      = step && ((take == rem_q) || (key_done && (tile_q == '0)));
  end

  // Next state
  always_comb begin
    byte_d  = byte_q;
    rem_d   = rem_q;
    pkey_d  = pkey_q;
    pbits_d = pbits_q;
    tile_d  = tile_q;
    done_d  = done_q;

    if (step) begin
      byte_d = byte_q >> take;
      rem_d  = rem_q - take;
      if (key_done) begin
        pkey_d  = '0;
        pbits_d = '0;
        if (tile_q == '0) begin
          done_d = 1'b1;
          rem_d  = '0;
        end else begin
          tile_d = tile_q - pkbu_pkg::TileW'(1);
        end
      end else begin
        pkey_d  = pkey_new;
        pbits_d = pbits_q + pkbu_pkg::KCntW'(take);
      end
    end

    // key width change drops a half-collected key
    if (clr_i) begin
      pkey_d  = '0;
      pbits_d = '0;
    end

    // bytes after the last tile are dropped
    if (load_i && !done_d) begin
      byte_d = byte_i;
      rem_d  = pkbu_pkg::RemW'(pkbu_pkg::ByteW);
    end

    // palette write after the chunk end starts a new chunk
    if (rearm_i && done_d) begin
      tile_d  = pkbu_pkg::TileW'(pkbu_pkg::TilesPerChunk - 1);
      done_d  = 1'b0;
      pkey_d  = '0;
      pbits_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      pkey_q  <= '0;
      pbits_q <= '0;
      tile_q  <= pkbu_pkg::TileW'(pkbu_pkg::TilesPerChunk - 1);
      done_q  <= 1'b0;
    end else begin
      rem_q   <= rem_d;
      pkey_q  <= pkey_d;
      pbits_q <= pbits_d;
      tile_q  <= tile_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign ready_o       = !busy || fin;
  assign issue_o.valid = step && key_done;
  assign issue_o.key   = pkey_new;
  assign issue_o.tile  = tile_q;

endmodule

[dv/pkbu_checker.sv]
// Checker for the palette key bit unpacker: watches both channels, predicts tiles, compares.
`timescale 1ns / 1ps

module pkbu_checker
  import pkbu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [BaseW-1:0]   cfg_wdata_i,
  pkbu_in_if                 beat_i,
  pkbu_out_if                tile_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 tiles_o,
  output int                 bad_keys_o,
  output int                 chunks_o
);

  // One expected tile result
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [IdW-1:0]           id;
    logic                     bad;
    logic                     last;
  } tile_res_t;

  // Shadow of the block: palette, registers and unpacking state
  logic [IdW-1:0]          pal_mem [PaletteDepth];
  logic [SizeW-1:0]        pal_size;
  logic signed [BaseW-1:0] base_x;
  logic signed [BaseW-1:0] base_y;
  logic [KeyW-1:0]         acc_key;
  int                      acc_bits;
  logic [TileW-1:0]        tile_num;
  bit                      chunk_over;
  tile_res_t               pending_tiles [$];

  // Key width from the palette size, size capped at the palette depth
  function automatic int key_bits_for(input logic [SizeW-1:0] size);
    int lim;
    int k;
    lim = (int'(size) > PaletteDepth) ? PaletteDepth : int'(size);
    k   = 1;
    while ((1 << k) < lim) k++;
    return k;
  endfunction

  task automatic restart_chunk();
    acc_key    = '0;
    acc_bits   = 0;
    tile_num   = TileW'(TilesPerChunk - 1);
    chunk_over = 1'b0;
  endtask

  // Queue one expected tile behind the others
  task automatic expect_tile(input tile_res_t r);
    pending_tiles = {pending_tiles, r};
  endtask

  // Walk a byte from bit 0 upward, one expected tile per completed key
  task automatic unpack_byte(input logic [ByteW-1:0] b);
    int        k;
    int        key;
    tile_res_t r;
    k = key_bits_for(pal_size);
    for (int n = 0; n < ByteW && !chunk_over; n++) begin
      acc_key[acc_bits] = b[n];
      acc_bits++;
      if (acc_bits >= k) begin
        key    = int'(acc_key);
        r.bad  = (key >= int'(pal_size)) || (key >= PaletteDepth);
        r.id   = r.bad ? '0 : pal_mem[key];
        r.x    = CoordW'(int'(base_x) * RowWidth + int'(tile_num) % RowWidth);
        r.y    = CoordW'(int'(base_y) * RowWidth + int'(tile_num) / RowWidth);
        r.last = (tile_num == '0);
        expect_tile(r);
        acc_key  = '0;
        acc_bits = 0;
        if (tile_num == '0) chunk_over = 1'b1;
        else tile_num--;
      end
    end
  endtask

  // One line per mismatch, all counted
  task automatic report_mismatch(input string what);
    $display("[%0t] tile check: %s", $realtime, what);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [IdW-1:0] got,
                             input logic [IdW-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tile_res_t want;
    if (!rst_ni) begin
      pal_size = SizeW'(1);
      base_x   = '0;
      base_y   = '0;
      restart_chunk();
      pending_tiles.delete();
      fail_count_o = 0;
      tiles_o      = 0;
      bad_keys_o   = 0;
      chunks_o     = 0;
    end else begin
      // register writes; a new key width drops the partial key
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPaletteSize: begin
            pal_size = cfg_wdata_i[SizeW-1:0];
            acc_key  = '0;
            acc_bits = 0;
          end
          RegChunkBaseX: base_x = cfg_wdata_i;
          RegChunkBaseY: base_y = cfg_wdata_i;
          default: ;
        endcase
      end
      // input beat: palette write (re-arms a finished chunk) or packed byte
      if (beat_i.valid && beat_i.ready) begin
        if (beat_i.operation == OpPalette) begin
          pal_mem[beat_i.palette_index] = beat_i.palette_value;
          if (chunk_over) restart_chunk();
        end else begin
          unpack_byte(beat_i.packed_byte);
        end
      end
      // result beat against the oldest expectation
      if (tile_i.valid && tile_i.ready) begin
        tiles_o++;
        if (pending_tiles.size() == 0) begin
          report_mismatch("tile result with nothing expected");
        end else begin
          want = pending_tiles.pop_front();
          check_field("tile_x", IdW'($unsigned(tile_i.tile_x)), IdW'($unsigned(want.x)));
          check_field("tile_y", IdW'($unsigned(tile_i.tile_y)), IdW'($unsigned(want.y)));
          check_field("tile_id", tile_i.tile_id, want.id);
          check_field("bad_key", IdW'(tile_i.bad_key), IdW'(want.bad));
          check_field("last_tile", IdW'(tile_i.last_tile), IdW'(want.last));
          bad_keys_o += int'(want.bad);
          chunks_o   += int'(want.last);
        end
      end
    end
    pending_o = pending_tiles.size();
  end

endmodule

[dv/tb.sv]
// Testbench top: clock, reset, stimulus for the palette key bit unpacker, verdict.
`timescale 1ns / 1ps

module tb;
  import pkbu_pkg::*;

  // time for the last byte to pass the unpacker and pipeline; margin on top
  localparam int Settle     = 16;
  // longest quiet stretch is the receiver hold-off; limit taken well above it
  localparam int HoldOff    = 300;
  localparam int StallLimit = 3000;

  logic               clk   = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [BaseW-1:0]   cfg_wdata;

  int fail_cnt;
  int pending_cnt;
  int tile_cnt;
  int bad_cnt;
  int chunk_cnt;

  int idle_mode;
  int beats_sent;
  int settings_cnt;
  int stall_cnt;
  bit hold_req;
  bit hold_done;

  // Stimulus side: palette entries written so far, key geometry, bit packer
  bit          written [PaletteDepth];
  int          cur_lim;
  int          cur_kw;
  logic [31:0] pk_bits;
  int          pk_cnt;

  pkbu_in_if  beat_if ();
  pkbu_out_if tile_if ();

  palette_key_bit_unpacker_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (beat_if),
    .out_o       (tile_if)
  );

  pkbu_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .beat_i       (beat_if),
    .tile_i       (tile_if),
    .fail_count_o (fail_cnt),
    .pending_o    (pending_cnt),
    .tiles_o      (tile_cnt),
    .bad_keys_o   (bad_cnt),
    .chunks_o     (chunk_cnt)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle rates per mode: sender-light, receiver-light, none
  function automatic int send_idle_pct();
    case (idle_mode)
      0:       return 15;
      1:       return 86;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (idle_mode)
      0:       return 86;
      1:       return 15;
      default: return 0;
    endcase
  endfunction

  // Result side: random back-pressure, one long hold-off on request
  initial begin
    tile_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        tile_if.ready <= 1'b0;
        repeat (HoldOff) @(negedge clk);
      end else begin
        tile_if.ready <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  // Watchdog: cycles with no beat accepted on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((beat_if.valid && beat_if.ready) || (tile_if.valid && tile_if.ready))
        stall_cnt = 0;
      else
        stall_cnt++;
      if (stall_cnt >= StallLimit) begin
        $display("watchdog: no beat accepted for %0d cycles, %0d tiles outstanding",
                 stall_cnt, pending_cnt);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offer one beat from a falling edge and hold it until accepted
  task automatic send_beat(input logic op, input logic [KeyW-1:0] idx,
                           input logic [IdW-1:0] val, input logic [ByteW-1:0] byt);
    while ($urandom_range(99) < send_idle_pct()) begin
      beat_if.valid <= 1'b0;
      @(negedge clk);
    end
    beat_if.valid         <= 1'b1;
    beat_if.operation     <= op;
    beat_if.palette_index <= idx;
    beat_if.palette_value <= val;
    beat_if.packed_byte   <= byt;
    do @(posedge clk); while (!beat_if.ready);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_entry(input logic [KeyW-1:0] idx, input logic [IdW-1:0] val);
    send_beat(OpPalette, idx, val, ByteW'($urandom));
    written[idx] = 1'b1;
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b);
    send_beat(OpByte, KeyW'($urandom), {$urandom, $urandom}, b);
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return ByteW'($urandom);
    endcase
  endfunction

  // Key width and lookup limit for a palette size; the block drops its partial key
  task automatic set_geometry(input logic [SizeW-1:0] size);
    cur_lim = (int'(size) > PaletteDepth) ? PaletteDepth : int'(size);
    cur_kw  = 1;
    while ((1 << cur_kw) < cur_lim) cur_kw++;
    pk_bits = '0;
    pk_cnt  = 0;
  endtask

  // Some bad keys; every good key names a palette entry already written
  function automatic int pick_key();
    int key;
    int top;
    top = (1 << cur_kw) - 1;
    if (cur_lim == 0 || (cur_lim <= top && $urandom_range(99) < 20))
      return int'($urandom_range(top, cur_lim));
    key = int'($urandom_range(cur_lim - 1));
    for (int t = 0; t < 4096 && !written[key]; t++) key = int'($urandom_range(cur_lim - 1));
    return written[key] ? key : 0;
  endfunction

  // Pack a key low bits first and send each byte as it fills
  task automatic send_key(input int key);
    pk_bits = pk_bits | (32'(key) << pk_cnt);
    pk_cnt += cur_kw;
    while (pk_cnt >= ByteW) begin
      send_byte(pk_bits[ByteW-1:0]);
      pk_bits = pk_bits >> ByteW;
      pk_cnt -= ByteW;
    end
  endtask

  // Drop valid, wait for every tile, then let the last byte drain
  task automatic wait_idle();
    beat_if.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (Settle) @(negedge clk);
  endtask

  // All three registers, written back to back once the block is idle
  task automatic set_config(input logic [SizeW-1:0] size, input logic [BaseW-1:0] bx,
                            input logic [BaseW-1:0] by);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= RegPaletteSize;
    cfg_wdata <= BaseW'(size);
    @(negedge clk);
    cfg_idx   <= RegChunkBaseX;
    cfg_wdata <= bx;
    @(negedge clk);
    cfg_idx   <= RegChunkBaseY;
    cfg_wdata <= by;
    @(negedge clk);
    cfg_we    <= 1'b0;
    set_geometry(size);
    settings_cnt++;
  endtask

  // Mostly keys, some palette writes at random places
  task automatic random_run(input int n_items, input int write_pct);
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(99) < write_pct)
        send_entry(KeyW'($urandom_range(PaletteDepth - 1)), {$urandom, $urandom});
      else
        send_key(pick_key());
    end
  endtask

  initial begin
    cfg_we                <= 1'b0;
    cfg_idx               <= '0;
    cfg_wdata             <= '0;
    beat_if.valid         <= 1'b0;
    beat_if.operation     <= OpPalette;
    beat_if.palette_index <= '0;
    beat_if.palette_value <= '0;
    beat_if.packed_byte   <= '0;
    idle_mode    = 0;
    beats_sent   = 0;
    settings_cnt = 0;
    stall_cnt    = 0;
    hold_req     = 1'b0;
    hold_done    = 1'b0;
    set_geometry(SizeW'(1));
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A few palette entries; lookups only ever pick written ones
    send_entry(KeyW'(0), '0);
    for (int i = 1; i < 6; i++) send_entry(KeyW'(i), {$urandom, $urandom});
    send_entry(KeyW'(PaletteDepth / 2), {$urandom, $urandom});
    send_entry(KeyW'(PaletteDepth - 1), '1);

    // Directed: reset settings, one-bit keys, key 1 is bad
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    // empty palette: every key bad
    set_config(SizeW'(0), 16'h0000, 16'h0000);
    send_byte(8'h5A);
    // full palette, base extremes, 10-bit keys across byte boundaries
    set_config(SizeW'(PaletteDepth), 16'h8000, 16'h7FFF);
    send_key(PaletteDepth - 1);
    send_key(0);
    send_key(PaletteDepth / 2);
    send_key(5);
    // oversized palette size: width capped, no key is bad; a mid-chunk palette
    // write only stores, and the next key 1023 sees the new entry
    set_config(SizeW'(2047), 16'h7FFF, 16'h8000);
    send_key(PaletteDepth - 1);
    send_key(3);
    send_entry(KeyW'(PaletteDepth - 1), 64'h0123_4567_89AB_CDEF);
    send_key(PaletteDepth - 1);
    send_key(4);
    // 9-bit keys: the eighth one starts at bit 7 and spans two bytes
    set_config(SizeW'(500), 16'h0001, 16'hFFFF);
    repeat (8) send_key(pick_key());
    // partial key dropped by a key width change
    send_key(pick_key());
    set_config(SizeW'(3), 16'hFFFF, 16'h0001);
    repeat (8) send_key(pick_key());

    // Random, sender idling lightly, receiver heavily
    set_config(SizeW'($urandom_range(1, PaletteDepth)), BaseW'($urandom), BaseW'($urandom));
    random_run(10, 15);

    // Random, the other way round
    idle_mode = 1;
    set_config(SizeW'($urandom_range(PaletteDepth + 1, 2047)), BaseW'($urandom),
               BaseW'($urandom));
    random_run(10, 15);
    set_config(SizeW'($urandom_range(2, 16)), BaseW'($urandom), BaseW'($urandom));
    random_run(12, 15);

    // No idling: run the chunk to its end under a long receiver hold-off,
    // bytes past the last tile are dropped until a palette write re-arms
    idle_mode = 2;
    set_config(SizeW'(1), 16'h7FFF, 16'h8000);
    hold_req = 1'b1;
    for (int n = 0; n < TilesPerChunk / ByteW && tile_cnt + pending_cnt < TilesPerChunk; n++)
      send_byte(pick_byte());
    repeat (3) send_byte(pick_byte());
    send_entry(KeyW'($urandom_range(PaletteDepth - 1)), {$urandom, $urandom});
    repeat (3) send_byte(pick_byte());

    wait_idle();
    $display("Covered %0d beats over %0d register settings:", beats_sent, settings_cnt);
    $display("  %0d tiles, %0d bad keys, %0d chunk ends", tile_cnt, bad_cnt, chunk_cnt);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
